// File: rtl/kst_pkg.sv
// Shared types, constants and helper functions of the keyed slot table.
`default_nettype none

package kst_pkg;

	// Table geometry.
	localparam int SLOT_COUNT = 8;
	localparam int KEY_CHARS  = 8;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Field widths.
	localparam int KEY_W      = 64;
	localparam int LEN_W      = 16;
	localparam int ADDR_W     = 32;
	localparam int ATT_W      = 3;
	localparam int SLOT_IDX_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register reset values.
	localparam logic [ADDR_W-1:0] BASE_RESET  = 32'hC030_0000;
	localparam logic [LEN_W-1:0]  BYTES_RESET = 16'd16384;
	localparam logic [ATT_W-1:0]  LIMIT_RESET = 3'd3;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_FETCH  = 2'd1,
		ACT_STORE  = 2'd2,
		ACT_FAIL   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_OK      = 2'd0,
		RES_FULL    = 2'd1,
		RES_BADLEN  = 2'd2,
		RES_ZEROKEY = 2'd3
	} result_t;

	typedef enum logic [1:0] {
		ST_EMPTY  = 2'd0,
		ST_READY  = 2'd1,
		ST_FAILED = 2'd2
	} slot_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE  = 2'd0,
		CFG_BYTES = 2'd1,
		CFG_LIMIT = 2'd2
	} cfg_index_t;

	// Configuration register values handed to the table.
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  slot_bytes;
		logic [ATT_W-1:0]  limit;
	} cfg_t;

	// One response item.
	typedef struct packed {
		logic                  ready_hit;
		logic                  fetch_allowed;
		logic                  slot_found;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [ADDR_W-1:0]     slot_address;
		logic [LEN_W-1:0]      data_length;
		result_t               status;
	} rsp_t;

	// Keep the first KEY_CHARS characters up to the first zero byte.
	function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		logic             alive;
		k     = '0;
		alive = 1'b1;
		for (int i = 0; i < KEY_CHARS; i++) begin
			if (raw[8*i +: 8] == 8'h00) begin
				alive = 1'b0;
			end
			if (alive) begin
				k[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/kst_if.sv
// Handshake interfaces for the request, response and configuration channels.
`default_nettype none

interface kst_req_if import kst_pkg::*; ();
	logic             valid;
	logic             ready;
	action_t          action;
	logic [KEY_W-1:0] key;
	logic [LEN_W-1:0] length;

	modport source (output valid, action, key, length, input ready);
	modport sink (input valid, action, key, length, output ready);
endinterface

interface kst_rsp_if import kst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  ready_hit;
	logic                  fetch_allowed;
	logic                  slot_found;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [ADDR_W-1:0]     slot_address;
	logic [LEN_W-1:0]      data_length;
	result_t               status;

	modport source (output valid, ready_hit, fetch_allowed, slot_found, slot_index,
		slot_address, data_length, status, input ready);
	modport sink (input valid, ready_hit, fetch_allowed, slot_found, slot_index,
		slot_address, data_length, status, output ready);
endinterface

interface kst_cfg_if import kst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/kst_table.sv
// Slot storage with parallel key match, free-slot claim and status update.
`default_nettype none

module kst_table import kst_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             commit,
	input  wire action_t          action,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [LEN_W-1:0] length,
	input  wire cfg_t             cfg,
	output rsp_t                  rsp
);

	logic [KEY_W-1:0]  key_q     [SLOT_COUNT];
	slot_state_t       state_q   [SLOT_COUNT];
	logic [ATT_W-1:0]  att_q     [SLOT_COUNT];
	logic [LEN_W-1:0]  len_q     [SLOT_COUNT];

	logic [SLOT_COUNT-1:0] hit;
	logic [SLOT_COUNT-1:0] free;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      idx;
	logic                  zero_key;
	logic                  found;
	logic                  bad_len;
	slot_state_t           cur_state;
	logic [ATT_W-1:0]      cur_att;
	logic [LEN_W-1:0]      cur_len;
	slot_state_t           new_state;
	logic [ATT_W-1:0]      new_att;
	logic [LEN_W-1:0]      new_len;
	logic [IDX_W+LEN_W-1:0] offset;
	result_t               res;

	// Compare the key against every slot and find the lowest free slot.
	always_comb begin
		hit      = '0;
		free     = '0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			free[i] = (key_q[i] == '0);
			hit[i]  = !free[i] && (key_q[i] == key);
		end
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// Pick the slot and work out its state after the action.
	always_comb begin
		zero_key = (key == '0);
		idx      = (|hit) ? hit_idx : free_idx;
		if (zero_key) begin
			found = 1'b0;
		end else if (action == ACT_LOOKUP) begin
			found = |hit;
		end else begin
			found = (|hit) || (|free);
		end
		bad_len = (action == ACT_STORE) && ((length == '0) || (length > cfg.slot_bytes));

		// A claimed slot starts empty.
		if (|hit) begin
			cur_state = state_q[idx];
			cur_att   = att_q[idx];
			cur_len   = len_q[idx];
		end else begin
			cur_state = ST_EMPTY;
			cur_att   = '0;
			cur_len   = '0;
		end

		new_state = cur_state;
		new_att   = cur_att;
		new_len   = cur_len;
		if ((action == ACT_STORE) && !bad_len) begin
			new_state = ST_READY;
			new_len   = length;
		end else if (bad_len || (action == ACT_FAIL)) begin
			new_state = ST_FAILED;
			if (cur_att < cfg.limit) begin
				new_att = cur_att + ATT_W'(1);
			end
		end

		if (zero_key) begin
			res = RES_ZEROKEY;
		end else if (bad_len) begin
			res = RES_BADLEN;
		end else if ((action != ACT_LOOKUP) && !found) begin
			res = RES_FULL;
		end else begin
			res = RES_OK;
		end
	end

	// Slot address and response fields.
	always_comb begin
		offset = (IDX_W+LEN_W)'(idx) * (IDX_W+LEN_W)'(cfg.slot_bytes);
		rsp    = '0;
		rsp.status = res;
		if (found) begin
			rsp.ready_hit     = (new_state == ST_READY);
			rsp.fetch_allowed = (new_state == ST_EMPTY) ||
				((new_state == ST_FAILED) && (new_att < cfg.limit));
			rsp.slot_found    = 1'b1;
			rsp.slot_index    = SLOT_IDX_W'(idx);
			rsp.slot_address  = cfg.base + ADDR_W'(offset);
			rsp.data_length   = new_len;
		end
	end

	// Slot state update when the request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				key_q[i]   <= '0;
				state_q[i] <= ST_EMPTY;
				att_q[i]   <= '0;
				len_q[i]   <= '0;
			end
		end else if (commit && found && (action != ACT_LOOKUP)) begin
			key_q[idx]   <= key;
			state_q[idx] <= new_state;
			att_q[idx]   <= new_att;
			len_q[idx]   <= new_len;
		end
	end

endmodule

`default_nettype wire

// File: rtl/keyed_slot_table_with_retry.sv
// Keyed slot table: top level with request stage, response register and registers.
//
// Channels: req carries a request (action, key, length); rsp returns exactly one
// response per request, in order; cfg writes one of three registers (0 pool base,
// 1 slot bytes, 2 attempt limit) and is always ready, the value taking effect
// from the next cycle. Write registers only while no request is in flight.
// Flow: an accepted request is held in the input stage, matched against all
// eight slots there, and its response then goes to the response register,
// which waits while a stalled response is held. One request per cycle is
// taken unless the response stalls; this rests on the combinational key
// compare and claim and on the slot update between the input stage and the
// response register, which also makes each update visible to the next request.
// Reset clears all slots to free and empty, drops any pending request and
// response, and restores the register defaults.
// When the receiver stalls, the response is held and the input stage can still
// take one more request; req.ready then falls until the response is taken.
`default_nettype none

module keyed_slot_table_with_retry import kst_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	kst_req_if.sink   req,
	kst_rsp_if.source rsp,
	kst_cfg_if.sink   cfg
);

	logic             valid_s1;
	action_t          action_s1;
	logic [KEY_W-1:0] key_s1;
	logic [LEN_W-1:0] length_s1;
	logic             advance;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             table_rsp;
	cfg_t             cfg_q;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base       <= BASE_RESET;
			cfg_q.slot_bytes <= BYTES_RESET;
			cfg_q.limit      <= LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BASE:  cfg_q.base       <= cfg.data[ADDR_W-1:0];
				CFG_BYTES: cfg_q.slot_bytes <= cfg.data[LEN_W-1:0];
				CFG_LIMIT: cfg_q.limit      <= cfg.data[ATT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	// Input stage and response payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			key_s1    <= normalize_key(req.key);
			length_s1 <= req.length;
		end
		if (advance && valid_s1) begin
			rsp_q <= table_rsp;
		end
	end

	kst_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (valid_s1 && advance),
		.action (action_s1),
		.key    (key_s1),
		.length (length_s1),
		.cfg    (cfg_q),
		.rsp    (table_rsp)
	);

	// Response channel.
	assign rsp.valid         = rsp_valid_q;
	assign rsp.ready_hit     = rsp_q.ready_hit;
	assign rsp.fetch_allowed = rsp_q.fetch_allowed;
	assign rsp.slot_found    = rsp_q.slot_found;
	assign rsp.slot_index    = rsp_q.slot_index;
	assign rsp.slot_address  = rsp_q.slot_address;
	assign rsp.data_length   = rsp_q.data_length;
	assign rsp.status        = rsp_q.status;

endmodule

`default_nettype wire

// File: rtl/kst_checker.sv
// Port-level checks on the keyed slot table and the bind that attaches them.
`default_nettype none

module kst_checker import kst_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic              ready_hit,
	input wire logic              fetch_allowed,
	input wire logic              slot_found,
	input wire logic [ADDR_W-1:0] slot_address,
	input wire result_t           status
);

	// A zero key never finds a slot.
	a_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == RES_ZEROKEY) |-> !slot_found)
		else $error("zero key reported a slot");

	// Without a slot the ready hit, fetch allowed and slot address fields read zero.
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !slot_found |-> !ready_hit && !fetch_allowed && (slot_address == '0))
		else $error("slot fields set without a slot");

	// Ready data never allows another fetch.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(ready_hit && fetch_allowed))
		else $error("ready hit and fetch allowed together");

	// A rejected length never leaves the slot ready.
	a_badlen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == RES_BADLEN) |-> !ready_hit)
		else $error("bad length left slot ready");

	// A stalled response holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_address) && $stable(status))
		else $error("stalled response changed");

endmodule

bind keyed_slot_table_with_retry kst_checker u_kst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.ready_hit     (rsp.ready_hit),
	.fetch_allowed (rsp.fetch_allowed),
	.slot_found    (rsp.slot_found),
	.slot_address  (rsp.slot_address),
	.status        (rsp.status)
);

`default_nettype wire

// File: tb/sv/keyed_slot_table_with_retry_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the keyed slot table, with its own table predictor.

module keyed_slot_table_with_retry_tb;
	import kst_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_ITEMS  = 250;
	localparam int PHASES       = 7;
	localparam int QUIET_PHASE  = 3;
	localparam int TAIL_CYCLES  = 8;

	// Sample keys for the directed requests, first character in the low byte.
	localparam logic [KEY_W-1:0] KEY_WIDE    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_AB      = 64'h0000_0000_0000_6261;
	localparam logic [KEY_W-1:0] KEY_AB_TAIL = 64'h5A5A_5A5A_5A00_6261;
	localparam logic [KEY_W-1:0] KEY_HOLLOW  = 64'hFFFF_FFFF_FFFF_FF00;

	logic clk;
	logic arst_n;

	kst_req_if req_ch ();
	kst_rsp_if rsp_ch ();
	kst_cfg_if cfg_ch ();

	keyed_slot_table_with_retry u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predicted table contents and register values.
	logic [KEY_W-1:0]  table_key   [SLOT_COUNT];
	slot_state_t       table_state [SLOT_COUNT];
	logic [ATT_W-1:0]  table_tries [SLOT_COUNT];
	logic [LEN_W-1:0]  table_len   [SLOT_COUNT];
	logic [ADDR_W-1:0] reg_base;
	logic [LEN_W-1:0]  reg_slot_bytes;
	logic [ATT_W-1:0]  reg_limit;

	rsp_t        pending_responses[$];
	bit          quiet  = 1'b0;
	bit          failed = 1'b0;
	int unsigned cycles = 0;

	// Free-running clock, 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Random idle decision for either side; never idle during a quiet stretch.
	function automatic bit take_break();
		if (quiet) begin
			return 1'b0;
		end
		return $urandom_range(99) < 6;
	endfunction

	// A key ends at its first zero character or after KEY_CHARS characters.
	function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		int               n;
		k = '0;
		n = 0;
		while (n < KEY_CHARS && raw[8*n +: 8] != 8'h00) begin
			k[8*n +: 8] = raw[8*n +: 8];
			n++;
		end
		return k;
	endfunction

	// A failed attempt marks the slot failed and counts up to the limit.
	function automatic void record_failure(input int slot);
		table_state[slot] = ST_FAILED;
		if (table_tries[slot] < reg_limit) begin
			table_tries[slot] = table_tries[slot] + 1'b1;
		end
	endfunction

	// Apply one request to the predicted table and return the response it should give.
	function automatic rsp_t table_apply(input action_t act, input logic [KEY_W-1:0] raw,
		input logic [LEN_W-1:0] len);
		rsp_t             r;
		logic [KEY_W-1:0] k;
		int               slot;
		bit               bad;
		r        = '0;
		r.status = RES_OK;
		k        = trim_key(raw);
		slot     = -1;
		if (k == '0) begin
			r.status = RES_ZEROKEY;
			return r;
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (slot < 0 && table_key[i] == k) begin
				slot = i;
			end
		end
		// Every action except lookup claims the lowest free slot on a miss.
		if (act != ACT_LOOKUP) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slot < 0 && table_key[i] == '0) begin
					slot           = i;
					table_key[i]   = k;
					table_state[i] = ST_EMPTY;
					table_tries[i] = '0;
					table_len[i]   = '0;
				end
			end
			if (slot < 0) begin
				r.status = RES_FULL;
			end
		end
		if (act == ACT_STORE) begin
			bad = (len == '0) || (len > reg_slot_bytes);
			if (bad) begin
				r.status = RES_BADLEN;
				if (slot >= 0) begin
					record_failure(slot);
				end
			end else if (slot >= 0) begin
				table_state[slot] = ST_READY;
				table_len[slot]   = len;
			end
		end else if (act == ACT_FAIL && slot >= 0) begin
			record_failure(slot);
		end
		if (slot >= 0) begin
			r.ready_hit     = table_state[slot] == ST_READY;
			r.fetch_allowed = (table_state[slot] == ST_EMPTY) ||
				(table_state[slot] == ST_FAILED && table_tries[slot] < reg_limit);
			r.slot_found    = 1'b1;
			r.slot_index    = slot[SLOT_IDX_W-1:0];
			r.slot_address  = reg_base + ADDR_W'(slot) * ADDR_W'(reg_slot_bytes);
			r.data_length   = table_len[slot];
		end
		return r;
	endfunction

	// Send one request and record its expected response once it is accepted.
	task automatic send_request(input action_t act, input logic [KEY_W-1:0] raw,
		input logic [LEN_W-1:0] len);
		@(negedge clk);
		while (take_break()) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.key    <= raw;
		req_ch.length <= len;
		do @(posedge clk); while (!req_ch.ready);
		pending_responses.push_back(table_apply(act, raw, len));
	endtask

	// Stop sending and wait until every outstanding request has been answered.
	task automatic drain_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_responses.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Write one register and mirror it in the predictor.
	task automatic write_register(input cfg_index_t which, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (which)
			CFG_BASE: begin
				reg_base = value[ADDR_W-1:0];
			end
			CFG_BYTES: begin
				reg_slot_bytes = value[LEN_W-1:0];
			end
			CFG_LIMIT: begin
				reg_limit = value[ATT_W-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Registers change only with the table idle.
	task automatic set_registers(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] bytes,
		input logic [ATT_W-1:0] limit);
		drain_requests();
		write_register(CFG_BASE, CFG_DATA_W'(base));
		write_register(CFG_BYTES, CFG_DATA_W'(bytes));
		write_register(CFG_LIMIT, CFG_DATA_W'(limit));
	endtask

	// Random nonzero characters, n of them.
	function automatic logic [KEY_W-1:0] random_chars(input int n);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < n; i++) begin
			k[8*i +: 8] = 8'($urandom_range(1, 255));
		end
		return k;
	endfunction

	// Fill the bytes past a key's terminator with junk that must be ignored.
	function automatic logic [KEY_W-1:0] dress_key(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		int               n;
		r = k;
		n = 0;
		while (n < KEY_CHARS && k[8*n +: 8] != 8'h00) begin
			n++;
		end
		for (int i = n + 1; i < KEY_CHARS; i++) begin
			r[8*i +: 8] = 8'($urandom_range(0, 255));
		end
		return r;
	endfunction

	// Mostly keys already in the table, the rest zero keys, junk and new names.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned      r;
		logic [KEY_W-1:0] k;
		r = $urandom_range(99);
		k = {$urandom, $urandom};
		if (r < 70) begin
			k = dress_key(table_key[$urandom_range(SLOT_COUNT - 1)]);
		end else if (r < 76) begin
			k[7:0] = 8'h00;
		end else if (r >= 88) begin
			k = dress_key(random_chars($urandom_range(1, KEY_CHARS)));
		end
		return k;
	endfunction

	// Mostly lengths that fit, plus zero, the exact slot size and oversize ones.
	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65 && reg_slot_bytes != '0) begin
			return LEN_W'($urandom_range(1, reg_slot_bytes));
		end else if (r < 72) begin
			return reg_slot_bytes;
		end else if (r < 80) begin
			return '0;
		end else if (r < 90 && reg_slot_bytes != '1) begin
			return LEN_W'($urandom_range(int'(reg_slot_bytes) + 1, 65535));
		end
		return LEN_W'($urandom_range(0, 65535));
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// Compare one accepted response with the oldest expectation.
	task automatic check_response();
		rsp_t want;
		if (pending_responses.size() == 0) begin
			$error("response with no request outstanding");
			failed = 1'b1;
			return;
		end
		want = pending_responses.pop_front();
		check_field("ready_hit", 64'(want.ready_hit), 64'(rsp_ch.ready_hit));
		check_field("fetch_allowed", 64'(want.fetch_allowed), 64'(rsp_ch.fetch_allowed));
		check_field("slot_found", 64'(want.slot_found), 64'(rsp_ch.slot_found));
		check_field("slot_index", 64'(want.slot_index), 64'(rsp_ch.slot_index));
		check_field("slot_address", 64'(want.slot_address), 64'(rsp_ch.slot_address));
		check_field("data_length", 64'(want.data_length), 64'(rsp_ch.data_length));
		check_field("status", 64'(want.status), 64'(rsp_ch.status));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			check_response();
		end
	end

	// Receiver: takes responses, stalling now and then.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= !take_break();
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Lookups on an empty table, and keys that start with a zero character.
	task automatic test_empty_table();
		send_request(ACT_LOOKUP, KEY_WIDE, 16'd5);
		send_request(ACT_FETCH, '0, '0);
		send_request(ACT_FAIL, KEY_HOLLOW, 16'hFFFF);
	endtask

	// Claim, store, length checks and the saturating retry count.
	task automatic test_claim_store_retry();
		send_request(ACT_FETCH, KEY_WIDE, '0);
		send_request(ACT_STORE, KEY_WIDE, 16'd16384);
		send_request(ACT_LOOKUP, KEY_WIDE, '0);
		send_request(ACT_STORE, KEY_WIDE, 16'd16385);
		send_request(ACT_STORE, KEY_AB, '0);
		// Junk past the terminator still matches the short key.
		repeat (3) begin
			send_request(ACT_FAIL, KEY_AB_TAIL, 16'd7);
		end
		send_request(ACT_STORE, KEY_AB, 16'hFFFF);
		send_request(ACT_STORE, KEY_AB_TAIL, 16'd1);
	endtask

	// Fill the remaining slots, then misses on a full table.
	task automatic test_table_full();
		logic [KEY_W-1:0] stranger;
		for (int n = 3; n <= KEY_CHARS; n++) begin
			send_request(ACT_FETCH, dress_key(random_chars(n)), '0);
		end
		stranger        = random_chars(KEY_CHARS - 1);
		stranger[63:56] = 8'h7E;
		send_request(ACT_FETCH, stranger, '0);
		send_request(ACT_STORE, stranger, '0);
		send_request(ACT_STORE, stranger, 16'd100);
	endtask

	// Register extremes: address wrap, smallest slots, zero limit, zero slot size.
	task automatic test_register_extremes();
		set_registers(32'hFFFF_FFFF, 16'd32768, 3'd7);
		send_request(ACT_STORE, KEY_AB, 16'd32768);
		send_request(ACT_FAIL, KEY_WIDE, '0);
		set_registers('0, 16'd1, 3'd0);
		send_request(ACT_STORE, KEY_WIDE, 16'd1);
		send_request(ACT_STORE, KEY_WIDE, 16'd2);
		drain_requests();
		write_register(CFG_BYTES, '0);
		send_request(ACT_STORE, KEY_AB, 16'd1);
	endtask

	// Random traffic over several register settings, one phase without idling.
	task automatic test_random_traffic();
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  bytes;
		logic [ATT_W-1:0]  limit;
		for (int p = 0; p < PHASES; p++) begin
			base  = $urandom;
			bytes = ($urandom_range(1) != 0) ? LEN_W'($urandom_range(1, 64))
				: LEN_W'($urandom_range(1, 32768));
			limit = ATT_W'($urandom_range(0, 7));
			if (p == 0) begin
				base  = '1;
				bytes = 16'd32768;
				limit = 3'd7;
			end else if (p == 1) begin
				base  = '0;
				bytes = 16'd1;
				limit = 3'd0;
			end
			set_registers(base, bytes, limit);
			quiet = (p == QUIET_PHASE);
			repeat (PHASE_ITEMS) begin
				send_request(action_t'($urandom_range(3)), pick_key(), pick_length());
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.action = ACT_LOOKUP;
		req_ch.key    = '0;
		req_ch.length = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = CFG_BASE;
		cfg_ch.data   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			table_key[i]   = '0;
			table_state[i] = ST_EMPTY;
			table_tries[i] = '0;
			table_len[i]   = '0;
		end
		reg_base       = BASE_RESET;
		reg_slot_bytes = BYTES_RESET;
		reg_limit      = LIMIT_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_claim_store_retry();
		test_table_full();
		test_register_extremes();
		test_random_traffic();

		drain_requests();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed && pending_responses.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
